// ===== src/lzo_pkg.sv =====
// ----------------------------------------------------------------------------
// lzo_pkg - shared types and constants for the layer z-order manager
// Command codes, controller states, command/status structs, field widths.
// ----------------------------------------------------------------------------
package lzo_pkg;

	localparam int MAX_LAYERS_DEF = 256;

	localparam int ID_W      = 8;   // layer_id / alloc_id
	localparam int REQ_W     = 10;  // new_height, signed
	localparam int HEIGHT_W  = 9;   // stored heights, signed
	localparam int X_W       = 11;  // working width for height arithmetic

	localparam int IN_DATA_W  = 24; // layer_id + new_height, padded to bytes
	localparam int OUT_DATA_W = 56; // eight result fields, padded to bytes

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_NONE = '1; // -1, hidden

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_SET   = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PLAN,
		ST_SHIFT,
		ST_PLACE,
		ST_SCAN,
		ST_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic plan;
		logic shift;
		logic place;
		logic scan;
		logic respond;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;        // addressed layer in pool and in use
		logic move;       // clamped height differs from current
		logic shift_busy; // steps left or a write still in flight
		logic scan_done;  // free layer found or last layer checked
		logic out_free;   // result register can take a word
	} dp_status_t;

endpackage

// ===== src/layer_z_order_manager.sv =====
// ----------------------------------------------------------------------------
// layer_z_order_manager - window layer stacking-order manager
// Allocates, restacks and frees display layers; reports redraw ranges.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit first)                          | tuser
//  ---------+-----+------------------------------------------------+-------
//  s_       | in  | layer_id[7:0], new_height[9:0] (signed), pad   | cmd
//  m_       | out | status, alloc_id[7:0], applied_height[8:0],    | -
//           |     | top_height[8:0], redraw, map_from[8:0],        |
//           |     | draw_low[8:0], draw_high[8:0], pad             |
//
//  One command word in flight at a time. Allocate scans the in-use bits from
//  layer 0 up to the lowest free one. Set height / free: lookup, then plan;
//  if the height stays, the response follows. A move shifts the order entries
//  in the way, one entry per cycle through the order RAM read port, waits for
//  the last write to land (at most MAX_LAYERS - 1 entries shifted), places
//  the layer and responds. Ignored commands skip to the response step.
//  A result waiting on m_tready does not block acceptance of the next word;
//  only its own response step waits.
//  Reset clears in-use bits and sets top to -1; no RAM clearing pass is needed
//  as entries are only read once written.
//
module layer_z_order_manager #(
	parameter int MAX_LAYERS = lzo_pkg::MAX_LAYERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] layer_id, [17:8] new_height, [23:18] zero
	input  logic [lzo_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] cmd
	input  logic [1:0]                      s_tuser,

	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] status, [8:1] alloc_id, [17:9] applied_height, [26:18] top_height,
	// [27] redraw, [36:28] map_from, [45:37] draw_low, [54:46] draw_high,
	// [55] zero
	output logic [lzo_pkg::OUT_DATA_W-1:0]  m_tdata
);

	lzo_pkg::ctl_cmd_t   ctl_cmd;
	lzo_pkg::dp_status_t dp_st;

	// sequencer: decides which datapath step runs each cycle
	lzo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.st       (dp_st),
		.cmd      (ctl_cmd)
	);

	// storage, clamp/plan arithmetic, shift engine, result register
	lzo_datapath #(.MAX_LAYERS(MAX_LAYERS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.st        (dp_st),
		.in_op     (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef ASSERT_OFF
	// idle means the shift engine has drained
	a_idle_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dp_st.shift_busy)
		else $error("shift engine busy while accepting a word");

	// a new result only appears after a response step
	a_rise_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl_cmd.respond))
		else $error("result valid without response step");

	// no redraw means empty ranges
	a_no_redraw_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[27]) |-> (m_tdata[36:28] == 9'd0 &&
			m_tdata[45:37] == 9'd0 && m_tdata[54:46] == 9'h1FF))
		else $error("redraw clear but ranges set");

	// failed allocation reports id zero
	a_full_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
		else $error("pool full with non-zero id");
`endif

endmodule

// ===== src/lzo_ram.sv =====
// ----------------------------------------------------------------------------
// lzo_ram - generic simple dual-port RAM
// One write port, one read port, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module lzo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/lzo_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzo_ctrl - sequencer for the layer z-order manager
// Steps one command word through lookup, planning, shifting or an allocation scan, and response.
// ----------------------------------------------------------------------------
module lzo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	input  lzo_pkg::dp_status_t st,
	output lzo_pkg::ctl_cmd_t   cmd
);

	lzo_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzo_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			lzo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_op)
						lzo_pkg::OP_ALLOC: state_nxt = lzo_pkg::ST_SCAN;
						lzo_pkg::OP_SET,
						lzo_pkg::OP_FREE:  state_nxt = lzo_pkg::ST_CHECK;
						default:           state_nxt = lzo_pkg::ST_RESP;
					endcase
				end
			end
			lzo_pkg::ST_CHECK: begin
				cmd.lookup = 1'b1;
				state_nxt  = st.hit ? lzo_pkg::ST_PLAN : lzo_pkg::ST_RESP;
			end
			lzo_pkg::ST_PLAN: begin
				cmd.plan  = 1'b1;
				state_nxt = st.move ? lzo_pkg::ST_SHIFT : lzo_pkg::ST_RESP;
			end
			lzo_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (!st.shift_busy) begin
					state_nxt = lzo_pkg::ST_PLACE;
				end
			end
			lzo_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = lzo_pkg::ST_RESP;
			end
			lzo_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_nxt = lzo_pkg::ST_RESP;
				end
			end
			lzo_pkg::ST_RESP: begin
				if (st.out_free) begin
					cmd.respond = 1'b1;
					state_nxt   = lzo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lzo_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/lzo_datapath.sv =====
// ----------------------------------------------------------------------------
// lzo_datapath - storage and arithmetic of the layer z-order manager
// Order and height RAMs, in-use bits, top register, shift engine, result reg.
// ----------------------------------------------------------------------------
module lzo_datapath #(
	parameter int MAX_LAYERS = lzo_pkg::MAX_LAYERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lzo_pkg::ctl_cmd_t               cmd,
	output lzo_pkg::dp_status_t             st,
	input  logic [1:0]                      in_op,
	input  logic [lzo_pkg::IN_DATA_W-1:0]   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lzo_pkg::OUT_DATA_W-1:0]  out_data
);

	localparam int ADDR_W = $clog2(MAX_LAYERS);
	localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
	localparam int HW     = lzo_pkg::HEIGHT_W;
	localparam int IDW    = lzo_pkg::ID_W;
	localparam int RW     = lzo_pkg::REQ_W;
	localparam int XW     = lzo_pkg::X_W;
	localparam int ODW    = lzo_pkg::OUT_DATA_W;

	// latched command word
	logic [1:0]           op_q;
	logic [IDW-1:0]       id_q;
	logic signed [RW-1:0] req_q;
	logic                 hit_q;

	// block state
	logic [MAX_LAYERS-1:0] used_q;
	logic signed [HW-1:0]  top_q;

	// plan and shift engine
	logic signed [HW-1:0] reqc_q;
	logic                 hide_q, ins_q, up_q;
	logic [ADDR_W-1:0]    dst_q, dst_s1;
	logic [CNT_W-1:0]     cnt_q;
	logic                 vld_s1;
	logic [ADDR_W-1:0]    scan_q;

	// result fields
	logic                 status_q, redraw_q;
	logic [IDW-1:0]       alloc_q;
	logic signed [HW-1:0] applied_q, high_q;
	logic [HW-1:0]        map_q, low_q;
	logic                 out_valid_q;
	logic [ODW-1:0]       out_data_q;

	// RAM ports
	logic                 ord_we, ord_re, hgt_we;
	logic [ADDR_W-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rdata, hgt_waddr;
	logic [HW-1:0]        hgt_wdata, hgt_rdata;

	logic [ADDR_W-1:0]    id_idx;
	logic                 id_ok, hit, scan_free, scan_last, steps_left;

	// plan arithmetic
	logic signed [XW-1:0] old_x, req_x, top_x, lim_x, reqc_x, cnt_x, dst_x;
	logic                 move, lower, hide, rise, ins;

	assign id_idx     = id_q[ADDR_W-1:0];
	assign id_ok      = ({1'b0, id_q} < (IDW+1)'(MAX_LAYERS));
	assign hit        = id_ok && used_q[id_idx];
	assign scan_free  = !used_q[scan_q];
	assign scan_last  = (scan_q == ADDR_W'(MAX_LAYERS - 1));
	assign steps_left = (cnt_q != '0);

	always_comb begin
		old_x  = XW'($signed(hgt_rdata));
		req_x  = (op_q == lzo_pkg::OP_FREE) ? -XW'(1) : XW'(req_q);
		top_x  = XW'(top_q);
		lim_x  = old_x[XW-1] ? top_x + XW'(1) : top_x;
		reqc_x = (req_x > lim_x) ? lim_x : req_x;
		if (reqc_x < -XW'(1)) begin
			reqc_x = -XW'(1);
		end
		move  = (old_x != reqc_x);
		lower = (old_x > reqc_x) && !reqc_x[XW-1];
		hide  = (old_x > reqc_x) && reqc_x[XW-1];
		rise  = (old_x < reqc_x);
		ins   = rise && old_x[XW-1];
		// down: dst falls, src = dst-1; up: dst climbs, src = dst+1
		if (lower) begin
			cnt_x = old_x - reqc_x;
			dst_x = old_x;
		end else if (hide) begin
			cnt_x = top_x - old_x;
			dst_x = old_x;
		end else if (ins) begin
			cnt_x = top_x - reqc_x + XW'(1);
			dst_x = top_x + XW'(1);
		end else if (rise) begin
			cnt_x = reqc_x - old_x;
			dst_x = old_x;
		end else begin
			cnt_x = '0;
			dst_x = old_x;
		end
	end

	assign ord_re    = cmd.shift && steps_left;
	assign ord_raddr = up_q ? dst_q + ADDR_W'(1) : dst_q - ADDR_W'(1);

	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = dst_s1;
		ord_wdata = ord_rdata;
		hgt_we    = 1'b0;
		hgt_waddr = ord_rdata;
		hgt_wdata = HW'(dst_s1);
		if (vld_s1) begin
			ord_we = 1'b1;
			hgt_we = 1'b1;
		end else if (cmd.place) begin
			ord_we    = !reqc_q[HW-1];
			ord_waddr = reqc_q[ADDR_W-1:0];
			ord_wdata = id_idx;
			hgt_we    = 1'b1;
			hgt_waddr = id_idx;
			hgt_wdata = reqc_q;
		end else if (cmd.scan && scan_free) begin
			hgt_we    = 1'b1;
			hgt_waddr = scan_q;
			hgt_wdata = lzo_pkg::HEIGHT_NONE;
		end
	end

	lzo_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LAYERS)) u_order_ram (
		.clk     (clk),
		.wr_en   (ord_we),
		.wr_addr (ord_waddr),
		.wr_data (ord_wdata),
		.rd_en   (ord_re),
		.rd_addr (ord_raddr),
		.rd_data (ord_rdata)
	);

	lzo_ram #(.WIDTH(HW), .DEPTH(MAX_LAYERS)) u_height_ram (
		.clk     (clk),
		.wr_en   (hgt_we),
		.wr_addr (hgt_waddr),
		.wr_data (hgt_wdata),
		.rd_en   (cmd.lookup),
		.rd_addr (id_idx),
		.rd_data (hgt_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			top_q       <= lzo_pkg::HEIGHT_NONE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= ord_re;
			if (cmd.plan) begin
				cnt_q <= move ? CNT_W'(cnt_x) : '0;
			end else if (ord_re) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.scan && scan_free) begin
				used_q[scan_q] <= 1'b1;
			end
			if (cmd.respond && hit_q && (op_q == lzo_pkg::OP_FREE)) begin
				used_q[id_idx] <= 1'b0;
			end
			if (cmd.place) begin
				if (hide_q) begin
					top_q <= top_q - HW'(1);
				end else if (ins_q) begin
					top_q <= top_q + HW'(1);
				end
			end
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_op;
			id_q      <= in_data[IDW-1:0];
			req_q     <= in_data[IDW+RW-1:IDW];
			scan_q    <= '0;
			status_q  <= 1'b0;
			alloc_q   <= '0;
			applied_q <= lzo_pkg::HEIGHT_NONE;
			redraw_q  <= 1'b0;
			map_q     <= '0;
			low_q     <= '0;
			high_q    <= lzo_pkg::HEIGHT_NONE;
		end
		if (cmd.lookup) begin
			hit_q <= hit;
		end
		if (cmd.scan) begin
			if (scan_free) begin
				alloc_q <= IDW'(scan_q);
			end else if (scan_last) begin
				status_q <= 1'b1;
			end else begin
				scan_q <= scan_q + ADDR_W'(1);
			end
		end
		if (cmd.plan) begin
			reqc_q <= HW'(reqc_x);
			hide_q <= hide;
			ins_q  <= ins;
			up_q   <= hide || (rise && !ins);
			dst_q  <= ADDR_W'(dst_x);
			if (op_q == lzo_pkg::OP_SET) begin
				applied_q <= HW'(reqc_x);
			end
			if (move) begin
				redraw_q <= 1'b1;
				if (lower) begin
					map_q  <= HW'(reqc_x + XW'(1));
					low_q  <= HW'(reqc_x + XW'(1));
					high_q <= HW'(old_x);
				end else if (hide) begin
					map_q  <= '0;
					low_q  <= '0;
					high_q <= HW'(old_x - XW'(1));
				end else begin
					map_q  <= HW'(reqc_x);
					low_q  <= HW'(reqc_x);
					high_q <= HW'(reqc_x);
				end
			end
		end
		if (ord_re) begin
			dst_q  <= up_q ? dst_q + ADDR_W'(1) : dst_q - ADDR_W'(1);
			dst_s1 <= dst_q;
		end
		if (cmd.respond) begin
			out_data_q <= {1'b0, high_q, low_q, map_q, redraw_q, top_q, applied_q,
				alloc_q, status_q};
		end
	end

	assign st.hit        = hit;
	assign st.move       = move;
	assign st.shift_busy = steps_left || vld_s1;
	assign st.scan_done  = scan_free || scan_last;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
